// ===== rtl/lcdnc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the character LCD nibble command engine.
// No dependencies; imported by every module of the block.
package lcdnc_pkg;

  localparam int CharW   = 8;
  localparam int NibW    = 4;
  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int PosW    = 4;

  // byte codes
  localparam logic [CharW-1:0] ESC_RESET  = 8'h1B;
  localparam logic [CharW-1:0] CLEAR_BYTE = 8'hFF;
  localparam logic [CharW-1:0] HOME_CHAR  = 8'h40;
  localparam logic [CharW-1:0] CMD_CLEAR  = 8'h01;
  localparam logic [CharW-1:0] CMD_HOME   = 8'h02;

  // nibble positions within one queued word
  localparam logic [PosW-1:0] POS_FIRST     = 4'd0;
  localparam logic [PosW-1:0] POS_INIT_LAST = 4'd13;
  localparam logic [PosW-1:0] POS_HI        = 4'd14;
  localparam logic [PosW-1:0] POS_LO        = 4'd15;

  // register select codes
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // one classified word between the front and the back
  typedef struct packed {
    logic             init;    // prepend the power-up nibbles
    logic             has_op;  // a command or data byte follows
    logic             rs;      // register select of that byte
    logic [CharW-1:0] code;    // the byte itself
  } entry_t;

  // power-up nibbles: 3,3,3,2 then 0x28 0x0C 0x06 0x01 0x02 as hi/lo pairs
  function automatic logic [NibW-1:0] powerup_nibble(input logic [PosW-1:0] idx);
    logic [NibW-1:0] nib;
    unique case (idx)
      4'd0:    nib = 4'h3;
      4'd1:    nib = 4'h3;
      4'd2:    nib = 4'h3;
      4'd3:    nib = 4'h2;
      4'd4:    nib = 4'h2;
      4'd5:    nib = 4'h8;
      4'd6:    nib = 4'h0;
      4'd7:    nib = 4'hC;
      4'd8:    nib = 4'h0;
      4'd9:    nib = 4'h6;
      4'd10:   nib = 4'h0;
      4'd11:   nib = 4'h1;
      4'd12:   nib = 4'h0;
      4'd13:   nib = 4'h2;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// ===== rtl/lcdnc_front.sv =====
`timescale 1ns / 1ps
// Front part: holds the escape code register, classifies each input byte.
// Depends on lcdnc_pkg.
module lcdnc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lcdnc_pkg::CharW-1:0] cfg_wdata,
  input  logic                      acc_i,
  input  logic [lcdnc_pkg::CharW-1:0] char_i,
  output logic                      push_o,
  output lcdnc_pkg::entry_t         entry_o
);
  import lcdnc_pkg::*;

  logic [CharW-1:0] esc_code_r;
  logic             init_done_r, init_done_nxt;
  logic             esc_pend_r, esc_pend_nxt;

  always_comb begin
    entry_o        = '0;
    entry_o.init   = !init_done_r;
    entry_o.code   = char_i;
    entry_o.rs     = RS_INSTR;
    esc_pend_nxt   = esc_pend_r;
    init_done_nxt  = init_done_r;
    if (acc_i) begin
      init_done_nxt = 1'b1;
      esc_pend_nxt  = 1'b0;
    end
    priority if (esc_pend_r) begin
      if (char_i[CharW-1]) begin
        entry_o.has_op = 1'b1;
      end else if (char_i == HOME_CHAR) begin
        entry_o.has_op = 1'b1;
        entry_o.code   = CMD_HOME;
      end
    end else if (char_i == CLEAR_BYTE) begin
      entry_o.has_op = 1'b1;
      entry_o.code   = CMD_CLEAR;
    end else if (char_i == esc_code_r) begin
      if (acc_i) esc_pend_nxt = 1'b1;
    end else begin
      entry_o.has_op = 1'b1;
      entry_o.rs     = RS_DATA;
    end
    push_o = acc_i && (entry_o.init || entry_o.has_op);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_code_r  <= ESC_RESET;
      init_done_r <= 1'b0;
      esc_pend_r  <= 1'b0;
    end else begin
      if (cfg_we) esc_code_r <= cfg_wdata;
      init_done_r <= init_done_nxt;
      esc_pend_r  <= esc_pend_nxt;
    end
  end

endmodule

// ===== rtl/lcdnc_queue.sv =====
`timescale 1ns / 1ps
// Short word queue between the front and the back.
// Depends on lcdnc_pkg.
module lcdnc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  lcdnc_pkg::entry_t wr_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lcdnc_pkg::entry_t head_o
);
  import lcdnc_pkg::*;

  entry_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = (count_r != QCntW'(QDepth));
  assign valid_o = (count_r != '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= wr_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop_i)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      unique case ({push_i, pop_i})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/lcdnc_back.sv =====
`timescale 1ns / 1ps
// Back part: walks one queued word out as nibble writes into the output register.
// Depends on lcdnc_pkg.
module lcdnc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid_i,
  input  lcdnc_pkg::entry_t          head_i,
  output logic                       pop_o,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lcdnc_pkg::NibW-1:0] out_nibble,
  output logic                       out_reg_select,
  output logic                       out_last
);
  import lcdnc_pkg::*;

  logic            active_r, active_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            out_valid_r;
  logic [NibW-1:0] nib_r;
  logic            rs_r, last_r;

  logic            fire;
  logic [PosW-1:0] pos_cur, pos_end;
  logic [NibW-1:0] nib_cur;
  logic            rs_cur, last_cur;

  always_comb begin
    fire     = q_valid_i && (!out_valid_r || out_ready);
    pos_cur  = active_r ? pos_r : (head_i.init ? POS_FIRST : POS_HI);
    pos_end  = head_i.has_op ? POS_LO : POS_INIT_LAST;
    last_cur = (pos_cur == pos_end);
    unique case (pos_cur)
      POS_HI: begin
        nib_cur = head_i.code[CharW-1 -: NibW];
        rs_cur  = head_i.rs;
      end
      POS_LO: begin
        nib_cur = head_i.code[NibW-1:0];
        rs_cur  = head_i.rs;
      end
      default: begin
        nib_cur = powerup_nibble(pos_cur);
        rs_cur  = RS_INSTR;
      end
    endcase
    pop_o      = fire && last_cur;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    if (fire) begin
      active_nxt = !last_cur;
      pos_nxt    = pos_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      nib_r  <= nib_cur;
      rs_r   <= rs_cur;
      last_r <= last_cur;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nibble     = nib_r;
  assign out_reg_select = rs_r;
  assign out_last       = last_r;

`ifndef NO_ASSERTIONS
  // a word in progress keeps its queue entry until its final nibble
  a_active_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> q_valid_i) else $error("back active with empty queue");

  // a word without power-up nibbles is only ever mid-way at its low nibble
  a_plain_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !head_i.init) |-> (pos_r == POS_LO))
    else $error("unexpected position in plain word");

  // popping a word always loads its final nibble into the output register
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> (out_valid_r && last_r)) else $error("pop without last nibble");
`endif

endmodule

// ===== rtl/char_lcd_nibble_command_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the character LCD nibble command engine (4-bit interface).
// Depends on lcdnc_pkg, lcdnc_front, lcdnc_queue and lcdnc_back.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------
//   input    | in_char_code[7:0]                      | in_valid/in_ready
//   result   | out_nibble[3:0] out_reg_select out_last| out_valid/out_ready
//   config   | cfg_wdata[7:0] (escape code)           | cfg_we, no wait
//
// Nibbles: the back emits one nibble per cycle into the output register while
// out_ready is high, two per data or command word; the first word after reset
// adds the 14 power-up nibbles. A word that emits nothing never enters the queue.
// Reset: synchronous, active low; clears the escape state, the power-up flag,
// the queue and the output valid; the escape code returns to 0x1B.
// Stalls: in_ready drops only while the two-word queue is full; out_ready low holds the output.
module char_lcd_nibble_command_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lcdnc_pkg::CharW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lcdnc_pkg::CharW-1:0] in_char_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcdnc_pkg::NibW-1:0]  out_nibble,
  output logic                        out_reg_select,
  output logic                        out_last
);
  import lcdnc_pkg::*;

  logic   acc;       // input word taken this cycle
  logic   push;      // classified word goes into the queue
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  entry_t wr_entry;
  entry_t head;

  // accept whenever the queue has room, even for words that emit nothing
  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;

  lcdnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc_i     (acc),
    .char_i    (in_char_code),
    .push_o    (push),
    .entry_o   (wr_entry)
  );

  lcdnc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wr_i    (wr_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  lcdnc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  // only a full queue may hold off the input
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid) else $error("input stalled with empty queue");

  // the queue never reports empty right after a push without a pop
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> q_valid) else $error("pushed word lost");

  // data writes never come from the power-up part of a word
  a_data_rs: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.rs == RS_DATA) |-> head.has_op) else $error("data flag without op");
`endif

endmodule
